// ----- hw/rtl/pfcs_pkg.sv -----
`timescale 1ns / 1ps
package pfcs_pkg;
	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_IGNORED  = 3'd2,
		ST_UNKNOWN  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	localparam int ID_W    = 16;
	localparam int CNT_W   = 32;
	localparam int DUR_W   = 32;
	localparam int OUT_W   = 48;
	localparam int SLOT_W  = 6;
	localparam int IN_W    = 88;
	localparam int OUTD_W  = 304;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_REC  = 2'd1,
		OP_NORM = 2'd2
	} op_t;
endpackage

// ----- hw/rtl/pfcs_div.sv -----
`timescale 1ns / 1ps
module pfcs_div #(
	parameter int SW = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SW-1:0]             num,
	input  logic [pfcs_pkg::CNT_W-1:0] den,
	output logic                      busy,
	output logic                      done,
	output logic [SW-1:0]             quo
);
	import pfcs_pkg::*;
	localparam int CW = $clog2(SW + 1);

	logic [SW-1:0]    n_q;
	logic [CNT_W:0]   r_q;
	logic [CNT_W-1:0] d_q;
	logic [CW-1:0]    k_q;
	logic [CNT_W:0]   rs;

	assign rs   = {r_q[CNT_W-1:0], n_q[SW-1]};
	assign busy = (k_q != '0);
	assign quo  = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				k_q <= CW'(SW);
			end else if (busy) begin
				k_q <= k_q - 1'b1;
				if (k_q == CW'(1)) done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= (den == '0) ? CNT_W'(1) : den;
		end else if (busy) begin
			if (rs >= {1'b0, d_q}) begin
				r_q <= rs - {1'b0, d_q};
				n_q <= {n_q[SW-2:0], 1'b1};
			end else begin
				r_q <= rs;
				n_q <= {n_q[SW-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- hw/rtl/pfcs_cell.sv -----
`timescale 1ns / 1ps
module pfcs_cell #(
	parameter int SW = 48
) (
	input  logic                      clk,
	input  logic                      shift,
	input  logic                      wr,
	input  logic [pfcs_pkg::ID_W-1:0]  id_in,
	input  logic [pfcs_pkg::CNT_W-1:0] cnt_in,
	input  logic [SW-1:0]             dsum_in,
	input  logic [SW-1:0]             osum_in,
	input  logic [pfcs_pkg::DUR_W-1:0] lng_in,
	input  logic [pfcs_pkg::DUR_W-1:0] sht_in,
	output logic [pfcs_pkg::ID_W-1:0]  id_q,
	output logic [pfcs_pkg::CNT_W-1:0] cnt_q,
	output logic [SW-1:0]             dsum_q,
	output logic [SW-1:0]             osum_q,
	output logic [pfcs_pkg::DUR_W-1:0] lng_q,
	output logic [pfcs_pkg::DUR_W-1:0] sht_q
);
	import pfcs_pkg::*;
	always_ff @(posedge clk) begin
		if (shift || wr) begin
			id_q   <= id_in;
			cnt_q  <= cnt_in;
			dsum_q <= dsum_in;
			osum_q <= osum_in;
			lng_q  <= lng_in;
			sht_q  <= sht_in;
		end
	end
endmodule

// ----- hw/rtl/per_function_call_stats_table_core.sv -----
`timescale 1ns / 1ps
// Operation: a record or normalize word rotates all TABLE_DEPTH cells once before its result is
// registered; a record with id zero skips the rotation and answers directly.
// Normalize also holds the ring at each used entry while the serial divider runs.
// Flow: one word in flight; the next word can be accepted in the cycle after the result is
// registered, even while that result waits for m_tready.
// Reset (arst_n low, asynchronous) empties the table and clears all handshake state.
module per_function_call_stats_table_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int SUM_WIDTH   = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type, func_id, function_known, call_duration, call_own_time
	input  logic [pfcs_pkg::IN_W-1:0]   s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, slot, calls, total_duration, total_own_time, longest, shortest,
	// max_duration, max_avg_duration
	output logic [pfcs_pkg::OUTD_W-1:0] m_tdata
);
	import pfcs_pkg::*;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = SUM_WIDTH;
	localparam logic [SW-1:0] SMAX = '1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} state_t;
	state_t state_q;

	logic [ID_W-1:0]  c_id  [TABLE_DEPTH];
	logic [CNT_W-1:0] c_cnt [TABLE_DEPTH];
	logic [SW-1:0]    c_ds  [TABLE_DEPTH];
	logic [SW-1:0]    c_os  [TABLE_DEPTH];
	logic [DUR_W-1:0] c_lg  [TABLE_DEPTH];
	logic [DUR_W-1:0] c_sh  [TABLE_DEPTH];

	logic [UW-1:0] used_q, pos_q;
	logic          req_q, known_q, hit_q, shift;
	logic [ID_W-1:0] id_q;
	logic [DUR_W-1:0] dur_q, own_q;
	logic [SW-1:0] maxd_q, maxa_q;
	logic [AW-1:0] slot_q;
	logic [OUTD_W-1:0] out_q;
	logic           ovalid_q;
	logic           ins_flag_q;

	// head of ring is cell 0; tail cell TABLE_DEPTH-1 feeds back after update
	logic [ID_W-1:0]  t_id;
	logic [CNT_W-1:0] t_cnt, n_cnt;
	logic [SW-1:0]    t_ds, t_os, n_ds, n_os;
	logic [DUR_W-1:0] t_lg, t_sh, n_lg, n_sh;
	logic             t_live, t_hit, ins_now;
	logic [SW:0]      a_ds, a_os;

	assign t_id  = c_id[TABLE_DEPTH-1];
	assign t_cnt = c_cnt[TABLE_DEPTH-1];
	assign t_ds  = c_ds[TABLE_DEPTH-1];
	assign t_os  = c_os[TABLE_DEPTH-1];
	assign t_lg  = c_lg[TABLE_DEPTH-1];
	assign t_sh  = c_sh[TABLE_DEPTH-1];
	// slot of tail cell during rotation step pos_q is pos_q itself
	assign t_live = (pos_q < used_q);
	assign t_hit  = (state_q == S_SCAN) && !req_q && t_live && (t_id == id_q);
	assign ins_now = (state_q == S_SCAN) && !req_q && !hit_q && known_q &&
		(pos_q == used_q) && (used_q != UW'(TABLE_DEPTH));
	assign a_ds = {1'b0, t_ds} + {{(SW+1-DUR_W){1'b0}}, dur_q};
	assign a_os = {1'b0, t_os} + {{(SW+1-DUR_W){1'b0}}, own_q};

	always_comb begin
		n_cnt = t_cnt; n_ds = t_ds; n_os = t_os; n_lg = t_lg; n_sh = t_sh;
		if (t_hit) begin
			n_cnt = (t_cnt == '1) ? t_cnt : t_cnt + 1'b1;
			n_ds  = a_ds[SW] ? SMAX : a_ds[SW-1:0];
			n_os  = a_os[SW] ? SMAX : a_os[SW-1:0];
			n_lg  = (dur_q > t_lg) ? dur_q : t_lg;
			n_sh  = (dur_q < t_sh) ? dur_q : t_sh;
		end else if (ins_now) begin
			n_cnt = CNT_W'(1);
			n_ds  = SW'(dur_q);
			n_os  = SW'(own_q);
			n_lg  = dur_q;
			n_sh  = dur_q;
		end
	end

	assign shift = (state_q == S_SCAN);

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			pfcs_cell #(.SW(SW)) u_cell (
				.clk, .shift, .wr(1'b0),
				.id_in(ins_now ? id_q : t_id), .cnt_in(n_cnt), .dsum_in(n_ds),
				.osum_in(n_os), .lng_in(n_lg), .sht_in(n_sh),
				.id_q(c_id[g]), .cnt_q(c_cnt[g]), .dsum_q(c_ds[g]), .osum_q(c_os[g]),
				.lng_q(c_lg[g]), .sht_q(c_sh[g]));
		end else begin : g_body
			pfcs_cell #(.SW(SW)) u_cell (
				.clk, .shift, .wr(1'b0),
				.id_in(c_id[g-1]), .cnt_in(c_cnt[g-1]), .dsum_in(c_ds[g-1]),
				.osum_in(c_os[g-1]), .lng_in(c_lg[g-1]), .sht_in(c_sh[g-1]),
				.id_q(c_id[g]), .cnt_q(c_cnt[g]), .dsum_q(c_ds[g]), .osum_q(c_os[g]),
				.lng_q(c_lg[g]), .sht_q(c_sh[g]));
		end
	end

	// divider for normalize: runs while the ring is held
	logic          dv_start, dv_busy, dv_done;
	logic [SW-1:0] dv_q;
	assign dv_start = (state_q == S_SCAN) && req_q && t_live;
	pfcs_div #(.SW(SW)) u_div (
		.clk, .arst_n, .start(dv_start), .num(t_ds), .den(t_cnt),
		.busy(dv_busy), .done(dv_done), .quo(dv_q));

	logic [SW-1:0] s_ds;
	logic [CNT_W-1:0] s_cnt;
	logic [SW-1:0] s_os;
	logic [DUR_W-1:0] s_lg, s_sh;

	function automatic logic [OUT_W-1:0] w48(input logic [SW-1:0] v);
		logic [63:0] e;
		e = 64'(v);
		return e[OUT_W-1:0];
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;

	logic scan_hold;
	assign scan_hold = dv_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			pos_q    <= '0;
			ovalid_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						req_q   <= s_tdata[0];
						id_q    <= s_tdata[16:1];
						known_q <= s_tdata[17];
						dur_q   <= s_tdata[49:18];
						own_q   <= s_tdata[81:50];
						maxd_q  <= SW'(1);
						maxa_q  <= SW'(1);
						hit_q   <= 1'b0;
						pos_q   <= '0;
						if (!s_tdata[0] && s_tdata[16:1] == '0)
							state_q <= S_DONE;
						else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (t_hit || ins_now) begin
						hit_q  <= 1'b1;
						slot_q <= AW'(pos_q);
						s_cnt  <= n_cnt; s_ds <= n_ds; s_os <= n_os;
						s_lg   <= n_lg;  s_sh <= n_sh;
						if (ins_now) used_q <= used_q + 1'b1;
					end
					if (req_q && t_live && t_ds > maxd_q) maxd_q <= t_ds;
					pos_q <= pos_q + 1'b1;
					if (pos_q == UW'(TABLE_DEPTH - 1))
						state_q <= scan_hold ? S_DIV : S_DONE;
					else if (scan_hold)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (dv_done) begin
						if (dv_q > maxa_q) maxa_q <= dv_q;
						state_q <= (pos_q == UW'(TABLE_DEPTH)) ? S_DONE : S_SCAN;
					end
				end
				S_DONE: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
						if (req_q)
							out_q <= OUTD_W'({w48(maxa_q), w48(maxd_q), 198'd0,
								3'(ST_UPDATED)});
						else if (hit_q)
							out_q <= OUTD_W'({96'd0, s_sh, s_lg, w48(s_os), w48(s_ds), s_cnt,
								SLOT_W'(64'(slot_q)),
								(used_q != '0 && slot_q == AW'(used_q - 1'b1) && ins_flag_q)
								? 3'(ST_INSERTED) : 3'(ST_UPDATED)});
						else if (id_q == '0)
							out_q <= OUTD_W'(ST_IGNORED);
						else if (!known_q)
							out_q <= OUTD_W'(ST_UNKNOWN);
						else
							out_q <= OUTD_W'(ST_FULL);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ins_flag_q <= 1'b0;
		else if (state_q == S_IDLE) ins_flag_q <= 1'b0;
		else if (ins_now) ins_flag_q <= 1'b1;
	end

`ifndef SYNTH
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_DEPTH)) else $error("used count overflow");
	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		ins_now |-> !t_hit) else $error("insert on hit");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("ready while busy");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> !dv_busy) else $error("divider restarted while busy");
`endif
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import pfcs_pkg::*;

	localparam int DEPTH    = 64;
	localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [47:0] max_avg;
		logic [47:0] max_dur;
		logic [31:0] shortest;
		logic [31:0] longest;
		logic [47:0] own_sum;
		logic [47:0] dur_sum;
		logic [31:0] count;
		logic [5:0]  slot;
		logic [2:0]  status;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUTD_W-1:0] m_tdata;

	per_function_call_stats_table_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [IN_W-1:0] pending_words[$];
	stats_t expected_stats[$];
	int errors = 0;
	int results_seen = 0;
	int norm_seen = 0;
	int full_seen = 0;
	bit quiet = 0;
	int in_gap = 0;
	int out_gap = 0;
	int stall_cycles = 0;

	int unsigned tbl_used;
	logic [15:0] tbl_id[DEPTH];
	logic [31:0] tbl_cnt[DEPTH];
	logic [63:0] tbl_dur[DEPTH];
	logic [63:0] tbl_own[DEPTH];
	logic [31:0] tbl_long[DEPTH];
	logic [31:0] tbl_short[DEPTH];

	function automatic void queue_word(logic [IN_W-1:0] w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic int draw_gap();
		if (quiet || $urandom_range(0, 9) < 5)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(30, 90);
		return $urandom_range(1, 6);
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [31:0] b);
		logic [63:0] s;
		s = a + {32'd0, b};
		return (s > SUM_MAX) ? SUM_MAX : s;
	endfunction

	function automatic logic [IN_W-1:0] make_word(bit req, logic [15:0] id, bit known,
			logic [31:0] dur, logic [31:0] own);
		return {6'd0, own, dur, known, id, req};
	endfunction

	function automatic stats_t tally_call(logic [IN_W-1:0] w);
		stats_t r;
		logic [15:0] id;
		logic [31:0] dur;
		logic [63:0] c, a, maxd, maxa;
		int hit;
		id = w[16:1];
		dur = w[49:18];
		r = '0;
		hit = -1;
		if (w[0]) begin
			maxd = 64'd1;
			maxa = 64'd1;
			for (int i = 0; i < tbl_used; i++) begin
				c = (tbl_cnt[i] != 0) ? 64'(tbl_cnt[i]) : 64'd1;
				a = tbl_dur[i] / c;
				if (tbl_dur[i] > maxd) maxd = tbl_dur[i];
				if (a > maxa) maxa = a;
			end
			r.status = ST_UPDATED;
			r.max_dur = maxd[47:0];
			r.max_avg = maxa[47:0];
			return r;
		end
		if (id == 0) begin
			r.status = ST_IGNORED;
			return r;
		end
		for (int i = 0; i < tbl_used; i++)
			if (hit < 0 && tbl_id[i] == id) hit = i;
		if (hit >= 0) begin
			if (tbl_cnt[hit] != 32'hFFFF_FFFF) tbl_cnt[hit]++;
			tbl_dur[hit] = sat_sum(tbl_dur[hit], dur);
			tbl_own[hit] = sat_sum(tbl_own[hit], w[81:50]);
			if (dur > tbl_long[hit]) tbl_long[hit] = dur;
			if (dur < tbl_short[hit]) tbl_short[hit] = dur;
			r.status = ST_UPDATED;
		end else if (!w[17]) begin
			r.status = ST_UNKNOWN;
			return r;
		end else if (tbl_used >= DEPTH) begin
			r.status = ST_FULL;
			return r;
		end else begin
			hit = tbl_used++;
			tbl_id[hit] = id;
			tbl_cnt[hit] = 32'd1;
			tbl_dur[hit] = sat_sum(64'd0, dur);
			tbl_own[hit] = sat_sum(64'd0, w[81:50]);
			tbl_long[hit] = dur;
			tbl_short[hit] = dur;
			r.status = ST_INSERTED;
		end
		r.slot = hit[5:0];
		r.count = tbl_cnt[hit];
		r.dur_sum = tbl_dur[hit][47:0];
		r.own_sum = tbl_own[hit][47:0];
		r.longest = tbl_long[hit];
		r.shortest = tbl_short[hit];
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_stats.insert(expected_stats.size(), tally_call(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					s_tdata <= pending_words.pop_front();
					s_tvalid <= 1'b1;
					in_gap <= draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		stats_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(stats_t)-1:0];
				results_seen++;
				if (expected_stats.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, actual %0h", $time, got);
				end else begin
					want = expected_stats.pop_front();
					if (want.status == ST_FULL) full_seen++;
					if (want.max_dur != 0) norm_seen++;
					check_field("status", want.status, got.status);
					check_field("slot", want.slot, got.slot);
					check_field("calls", want.count, got.count);
					check_field("total_duration", want.dur_sum, got.dur_sum);
					check_field("total_own_time", want.own_sum, got.own_sum);
					check_field("longest", want.longest, got.longest);
					check_field("shortest", want.shortest, got.shortest);
					check_field("max_duration", want.max_dur, got.max_dur);
					check_field("max_avg_duration", want.max_avg, got.max_avg);
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				out_gap <= draw_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] id_pool[90];
		logic [31:0] dur, own;
		logic [15:0] id;
		int k;
		tbl_used = 0;
		for (int i = 0; i < 90; i++)
			id_pool[i] = 16'($urandom_range(1, 16'hFFFF));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queue_word(make_word(1'b1, 16'h0000, 1'b0, 32'd0, 32'd0));
		queue_word(make_word(1'b0, 16'h0000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		queue_word(make_word(1'b0, 16'h0005, 1'b0, 32'd10, 32'd3));
		queue_word(make_word(1'b0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		queue_word(make_word(1'b0, 16'hFFFF, 1'b0, 32'd0, 32'd0));
		queue_word(make_word(1'b0, 16'h0001, 1'b1, 32'd0, 32'd0));
		queue_word(make_word(1'b0, 16'h0001, 1'b1, 32'hFFFF_FFFF, 32'd7));
		queue_word(make_word(1'b0, 16'h0001, 1'b0, 32'd5, 32'hFFFF_FFFF));
		queue_word(make_word(1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		queue_word(make_word(1'b0, 16'h8000, 1'b0, 32'd1, 32'd1));

		for (int chunk = 0; chunk < 10; chunk++) begin
			wait (pending_words.size() == 0 && !s_tvalid && expected_stats.size() == 0);
			quiet = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 190; n++) begin
				k = $urandom_range(0, 99);
				case ($urandom_range(0, 9))
					0: dur = 32'd0;
					1: dur = 32'hFFFF_FFFF;
					default: dur = $urandom;
				endcase
				own = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
				if (k < 5)
					queue_word(make_word(1'b1, 16'($urandom), 1'($urandom), $urandom, $urandom));
				else if (k < 8)
					queue_word(make_word(1'b0, 16'h0000, 1'($urandom), dur, own));
				else begin
					id = (k < 16) ? 16'($urandom_range(1, 16'hFFFF))
						: id_pool[$urandom_range(0, 89)];
					queue_word(make_word(1'b0, id, $urandom_range(0, 99) < 85, dur, own));
				end
			end
		end

		wait (pending_words.size() == 0 && !s_tvalid && expected_stats.size() == 0);
		repeat (200) @(posedge clk);
		$display("Checked %0d result words: %0d normalize, %0d table-full, table held %0d entries.",
			results_seen, norm_seen, full_seen, tbl_used);
		if (errors == 0 && expected_stats.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/pfcs_pkg.sv
hw/rtl/pfcs_div.sv
hw/rtl/pfcs_cell.sv
hw/rtl/per_function_call_stats_table_core.sv
verif/testbench.sv
